// File: rtl/core/tcmp_pkg.sv
// package for the touch coordinate message parser
// holds parser state codes, ascii character codes, widths, coordinate limits and the result layout; no dependencies
package tcmp_pkg;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'd0,
    ST_OPEN  = 4'd1,
    ST_X     = 4'd2,
    ST_XNUM  = 4'd3,
    ST_XNEG  = 4'd4,
    ST_COMMA = 4'd5,
    ST_Y     = 4'd6,
    ST_YNUM  = 4'd7,
    ST_YNEG  = 4'd8,
    ST_END   = 4'd9
  } parse_state_t;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_X      = 8'h58;
  localparam logic [7:0] CH_Y      = 8'h59;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_ONE    = 8'h31;

  localparam int COORD_W = 16;
  localparam int AXIS_W  = 15;
  localparam int OUT_W   = 32;

  localparam logic signed [COORD_W-1:0] COORD_NONE = -16'sd1;
  localparam logic signed [20:0] COORD_MAX = 21'sd32767;
  localparam logic signed [20:0] RADIX     = 21'sd10;

  typedef struct packed {
    logic                     update_event;
    logic                     touch_valid;
    logic [AXIS_W-1:0]        touch_y;
    logic [AXIS_W-1:0]        touch_x;
  } result_t;

endpackage

// File: rtl/core/touch_coordinate_message_parser_top.sv
// top level of the touch coordinate message parser
// parses {X=n,Y=n} byte streams into a touch position; depends on tcmp_pkg
//
//  channel | dir | tdata bits (low to high)                               | notes
//  s_*     | in  | [7:0] rx_byte                                          | one char per transaction
//  m_*     | out | [14:0] touch_x, [29:15] touch_y, [30] touch_valid,     | one result per input
//          |     | [31] update_event                                      |
//
// one byte per cycle while s_tready is high; the parse step is a single state
// transition with a multiply by ten and saturating add, settled before the result
// register. each result is registered, in the skid entry if the output stalls.
// a two-entry output (result register plus skid) keeps s_tready high while one
// result waits; s_tready drops only when both are full.
// rst is synchronous: parser idle, position cleared to no touch, outputs empty.
module touch_coordinate_message_parser_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // [14:0] touch_x, [29:15] touch_y, [30] touch_valid, [31] update_event
);

  tcmp_pkg::parse_state_t             st, st_next;
  logic signed [tcmp_pkg::COORD_W-1:0] accum, accum_next;
  logic signed [tcmp_pkg::COORD_W-1:0] pend_x, pend_x_next;
  logic signed [tcmp_pkg::COORD_W-1:0] cur_x, cur_x_next;
  logic signed [tcmp_pkg::COORD_W-1:0] cur_y, cur_y_next;
  logic                                ev;
  logic signed [20:0]                  prod;
  logic [3:0]                          digit;
  logic                                is_digit;
  logic [7:0]                          c;
  tcmp_pkg::result_t                   res;
  logic [tcmp_pkg::OUT_W-1:0]          skid_data;
  logic                                skid_valid;
  logic                                accept;

  assign c        = s_tdata;
  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign digit    = 4'(c - tcmp_pkg::CH_ZERO);
  assign is_digit = (c >= tcmp_pkg::CH_ZERO) && (c <= tcmp_pkg::CH_NINE);

  always_comb begin
    prod = 21'(accum) * tcmp_pkg::RADIX + $signed({17'b0, digit});
  end

  always_comb begin
    st_next     = st;
    accum_next  = accum;
    pend_x_next = pend_x;
    cur_x_next  = cur_x;
    cur_y_next  = cur_y;
    ev          = 1'b0;
    priority if (c == tcmp_pkg::CH_LBRACE) begin
      st_next = tcmp_pkg::ST_OPEN;
    end else if (c == tcmp_pkg::CH_X) begin
      st_next = (st == tcmp_pkg::ST_OPEN) ? tcmp_pkg::ST_X : tcmp_pkg::ST_IDLE;
    end else if (c == tcmp_pkg::CH_Y) begin
      st_next = (st == tcmp_pkg::ST_COMMA) ? tcmp_pkg::ST_Y : tcmp_pkg::ST_IDLE;
    end else if (c == tcmp_pkg::CH_EQ) begin
      if (st == tcmp_pkg::ST_X) begin
        st_next    = tcmp_pkg::ST_XNUM;
        accum_next = '0;
      end else if (st == tcmp_pkg::ST_Y) begin
        st_next    = tcmp_pkg::ST_YNUM;
        accum_next = '0;
      end else begin
        st_next = tcmp_pkg::ST_IDLE;
      end
    end else if (c == tcmp_pkg::CH_MINUS) begin
      if (st == tcmp_pkg::ST_XNUM)      st_next = tcmp_pkg::ST_XNEG;
      else if (st == tcmp_pkg::ST_YNUM) st_next = tcmp_pkg::ST_YNEG;
      else                              st_next = tcmp_pkg::ST_IDLE;
    end else if (is_digit) begin
      if (st == tcmp_pkg::ST_XNUM || st == tcmp_pkg::ST_YNUM) begin
        // saturate at the largest coordinate
        accum_next = (prod > tcmp_pkg::COORD_MAX) ? tcmp_pkg::COORD_MAX[15:0] : prod[15:0];
      end else if ((st == tcmp_pkg::ST_XNEG || st == tcmp_pkg::ST_YNEG) &&
                   c == tcmp_pkg::CH_ONE) begin
        accum_next = tcmp_pkg::COORD_NONE;
      end else begin
        st_next = tcmp_pkg::ST_IDLE;
      end
    end else if (c == tcmp_pkg::CH_COMMA) begin
      if (st == tcmp_pkg::ST_XNUM || st == tcmp_pkg::ST_XNEG) begin
        pend_x_next = accum;
        st_next     = tcmp_pkg::ST_COMMA;
      end else begin
        st_next = tcmp_pkg::ST_IDLE;
      end
    end else if (c == tcmp_pkg::CH_RBRACE) begin
      if (st == tcmp_pkg::ST_YNUM || st == tcmp_pkg::ST_YNEG) begin
        st_next = tcmp_pkg::ST_END;
        if (cur_x != pend_x || cur_y != accum) begin
          cur_x_next = pend_x;
          cur_y_next = accum;
          ev         = 1'b1;
        end
      end else begin
        st_next = tcmp_pkg::ST_IDLE;
      end
    end else begin
      st_next = tcmp_pkg::ST_IDLE;
    end
  end

  always_comb begin
    res.touch_x      = cur_x_next[15] ? '0 : cur_x_next[14:0];
    res.touch_y      = cur_y_next[15] ? '0 : cur_y_next[14:0];
    res.touch_valid  = !cur_x_next[15] || !cur_y_next[15];
    res.update_event = ev;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st     <= tcmp_pkg::ST_IDLE;
      accum  <= '0;
      pend_x <= '0;
      cur_x  <= tcmp_pkg::COORD_NONE;
      cur_y  <= tcmp_pkg::COORD_NONE;
    end else if (accept) begin
      st     <= st_next;
      accum  <= accum_next;
      pend_x <= pend_x_next;
      cur_x  <= cur_x_next;
      cur_y  <= cur_y_next;
    end
  end

  // result register with a skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_tready || !m_tvalid) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        m_tdata    <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= accept;
        m_tdata  <= res;
      end
    end else if (accept) begin
      skid_data  <= res;
      skid_valid <= 1'b1;
    end
  end

endmodule

// File: verif/tcmp_checker.sv
// checker for the touch coordinate message parser: watches both stream channels,
// predicts the position reported for every accepted byte and compares it field by field
// depends on tcmp_pkg for state codes, character codes, widths and the result layout
module tcmp_checker
  import tcmp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  output int          fail_count,
  output int          pending
);

  parse_state_t                pstate;
  logic signed [COORD_W-1:0]   accum;
  logic signed [COORD_W-1:0]   latched_x;
  logic signed [COORD_W-1:0]   pos_x;
  logic signed [COORD_W-1:0]   pos_y;
  result_t                     position_q[$];
  int                          fails;

  initial begin
    fail_count = 0;
    pending    = 0;
    fails      = 0;
  end

  function automatic logic [AXIS_W-1:0] axis_value(input logic signed [COORD_W-1:0] v);
    if (v < 0) return '0;
    return v[AXIS_W-1:0];
  endfunction

  // one parser step: updates the shadow state and returns the reported position
  task automatic parse_byte(input logic [7:0] c, output result_t r);
    int   v;
    logic ev;
    ev = 1'b0;
    if (c == CH_LBRACE) begin
      pstate = ST_OPEN;
    end else if (c == CH_X) begin
      pstate = (pstate == ST_OPEN) ? ST_X : ST_IDLE;
    end else if (c == CH_Y) begin
      pstate = (pstate == ST_COMMA) ? ST_Y : ST_IDLE;
    end else if (c == CH_EQ) begin
      if (pstate == ST_X) begin
        pstate = ST_XNUM;
        accum  = '0;
      end else if (pstate == ST_Y) begin
        pstate = ST_YNUM;
        accum  = '0;
      end else begin
        pstate = ST_IDLE;
      end
    end else if (c == CH_MINUS) begin
      if (pstate == ST_XNUM) pstate = ST_XNEG;
      else if (pstate == ST_YNUM) pstate = ST_YNEG;
      else pstate = ST_IDLE;
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      if (pstate == ST_XNUM || pstate == ST_YNUM) begin
        v = int'(accum) * int'(RADIX) + int'(c - CH_ZERO);
        if (v > int'(COORD_MAX)) v = int'(COORD_MAX);
        accum = v[COORD_W-1:0];
      end else if ((pstate == ST_XNEG || pstate == ST_YNEG) && c == CH_ONE) begin
        accum = COORD_NONE;
      end else begin
        pstate = ST_IDLE;
      end
    end else if (c == CH_COMMA) begin
      if (pstate == ST_XNUM || pstate == ST_XNEG) begin
        latched_x = accum;
        pstate    = ST_COMMA;
      end else begin
        pstate = ST_IDLE;
      end
    end else if (c == CH_RBRACE) begin
      if (pstate == ST_YNUM || pstate == ST_YNEG) begin
        pstate = ST_END;
        if (pos_x != latched_x || pos_y != accum) begin
          pos_x = latched_x;
          pos_y = accum;
          ev    = 1'b1;
        end
      end else begin
        pstate = ST_IDLE;
      end
    end else begin
      pstate = ST_IDLE;
    end
    r.touch_x      = axis_value(pos_x);
    r.touch_y      = axis_value(pos_y);
    r.touch_valid  = (pos_x >= 0 || pos_y >= 0);
    r.update_event = ev;
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst) begin
      pstate    = ST_IDLE;
      accum     = '0;
      latched_x = '0;
      pos_x     = COORD_NONE;
      pos_y     = COORD_NONE;
      position_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (position_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
          fails++;
        end else begin
          want = position_q.pop_front();
          if (got.touch_x !== want.touch_x) begin
            $display("%0t: touch_x expected %0d actual %0d", $time, want.touch_x, got.touch_x);
            fails++;
          end
          if (got.touch_y !== want.touch_y) begin
            $display("%0t: touch_y expected %0d actual %0d", $time, want.touch_y, got.touch_y);
            fails++;
          end
          if (got.touch_valid !== want.touch_valid) begin
            $display("%0t: touch_valid expected %b actual %b", $time,
                     want.touch_valid, got.touch_valid);
            fails++;
          end
          if (got.update_event !== want.update_event) begin
            $display("%0t: update_event expected %b actual %b", $time,
                     want.update_event, got.update_event);
            fails++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        parse_byte(s_tdata, want);
        position_q.push_back(want);
      end
    end
    pending    <= position_q.size();
    fail_count <= fails;
  end

endmodule

// File: verif/tb_top.sv
// testbench top for touch_coordinate_message_parser_top: clock, reset, byte stimulus
// and receiver backpressure; prediction and comparison live in tcmp_checker
// depends on tcmp_pkg, tcmp_checker and the parser rtl
module tb_top;
  import tcmp_pkg::*;

  localparam int HOLD_CYCLES  = 200;
  localparam int PHASE_BYTES  = 283;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  int          fail_count;
  int          pending;

  int          src_idle;
  int          dst_idle;
  bit          hold_req;
  int          sent;
  logic [7:0]  msg_q[$];
  logic [7:0]  last_msg[$];

  touch_coordinate_message_parser_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  tcmp_checker u_chk (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  initial begin
    #(8 * 400000);
    $display("tb_top: done, errors");
    $finish;
  end

  // receiver: random ready, plus one long hold-off on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_tready <= ($urandom_range(0, 99) >= dst_idle);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_byte(s[i]);
  endtask

  task automatic push_dec(input int v);
    int digs[$];
    do begin
      digs.push_front(v % 10);
      v = v / 10;
    end while (v != 0);
    foreach (digs[i]) msg_q.push_back(8'(CH_ZERO + digs[i]));
  endtask

  // one coordinate field: plain, saturating, minus forms and leading zeros
  task automatic push_number();
    int kind;
    kind = $urandom_range(0, 9);
    case (kind)
      0: begin
        msg_q.push_back(CH_MINUS);
        msg_q.push_back(CH_ONE);
      end
      1: msg_q.push_back(CH_MINUS);
      2: begin
        case ($urandom_range(0, 3))
          0: push_dec(0);
          1: push_dec(1);
          2: push_dec(7);
          default: push_dec(int'(COORD_MAX));
        endcase
      end
      3: push_dec($urandom_range(32000, 999999));
      4: begin
        push_dec($urandom_range(0, 99));
        msg_q.push_back(CH_MINUS);
        msg_q.push_back(CH_ONE);
      end
      5: begin
        push_dec($urandom_range(0, 99));
        msg_q.push_back(CH_MINUS);
      end
      6: begin
        msg_q.push_back(CH_MINUS);
        repeat ($urandom_range(2, 4)) msg_q.push_back(CH_ONE);
      end
      7: begin
        repeat ($urandom_range(1, 3)) msg_q.push_back(CH_ZERO);
        push_dec($urandom_range(0, 9));
      end
      default: push_dec($urandom_range(0, 999));
    endcase
  endtask

  task automatic send_message();
    int idx;
    msg_q.delete();
    // resending the previous message exercises the unchanged-pair path
    if (last_msg.size() != 0 && $urandom_range(0, 5) == 0) begin
      msg_q = last_msg;
    end else begin
      msg_q.push_back(CH_LBRACE);
      msg_q.push_back(CH_X);
      msg_q.push_back(CH_EQ);
      push_number();
      msg_q.push_back(CH_COMMA);
      msg_q.push_back(CH_Y);
      msg_q.push_back(CH_EQ);
      push_number();
      msg_q.push_back(CH_RBRACE);
    end
    last_msg = msg_q;
    if ($urandom_range(0, 4) == 0) begin
      idx = $urandom_range(1, msg_q.size() - 1);
      case ($urandom_range(0, 3))
        0: msg_q[idx] = 8'($urandom);
        1: void'(msg_q.pop_back());
        2: msg_q.insert(idx, CH_LBRACE);
        default: msg_q.insert(idx, 8'(CH_ZERO + $urandom_range(2, 9)));
      endcase
    end
    foreach (msg_q[i]) send_byte(msg_q[i]);
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
    end
  endtask

  initial begin
    int goal;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    hold_req = 1'b0;
    sent     = 0;
    src_idle = 37;
    dst_idle = 70;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_byte(8'h00);
    send_byte(8'hFF);
    // minus after digits on x, saturation on y
    send_text("{X=12-1,Y=99999}");
    // parses to the same pair, so no event
    send_text("{X=-1,Y=40000}");

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          src_idle = 37;
          dst_idle = 70;
        end
        1: begin
          src_idle = 70;
          dst_idle = 37;
        end
        default: begin
          src_idle = 0;
          dst_idle = 0;
          hold_req = 1'b1;
        end
      endcase
      goal = sent + PHASE_BYTES;
      while (sent < goal) send_message();
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
